>>> rtl/core/bitmap_rle_run_decoder_core_defines.svh
// Assertion macros for the bitmap RLE run decoder checker.
// Expects signals clk and arst_n in the scope where the macros are used.
`ifndef BITMAP_RLE_RUN_DECODER_CORE_DEFINES_SVH
`define BITMAP_RLE_RUN_DECODER_CORE_DEFINES_SVH

// property checked at every clock edge outside reset
`define BRD_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// condition in one cycle implies a result in the next
`define BRD_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) else $error(msg);

`endif

>>> rtl/core/bmprle_pkg.sv
// Shared types and constants of the bitmap RLE run decoder.
// No dependencies; used by every module of the block.
`default_nettype none

package bmprle_pkg;

	localparam int DEF_MAX_WIDTH  = 4096;
	localparam int DEF_MAX_HEIGHT = 4096;

	localparam int BYTE_W     = 8;
	localparam int X_W        = 12;
	localparam int ROW_W      = 12;
	localparam int COUNT_W    = 21;
	localparam int IDX_W      = 8;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 13;

	localparam int QUEUE_DEPTH = 4;
	localparam int QUO_W       = 9;
	localparam int DIV_STEPS   = QUO_W;

	localparam logic [IDX_W-1:0] NIBBLE_MASK = 8'h0F;

	localparam logic [CFG_IDX_W-1:0] REG_NIBBLE_MODE  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_BOTTOM_UP    = 2'd3;

	localparam logic [BYTE_W-1:0] ESC_EOL   = 8'd0;
	localparam logic [BYTE_W-1:0] ESC_EOB   = 8'd1;
	localparam logic [BYTE_W-1:0] ESC_DELTA = 8'd2;

	typedef enum logic [2:0] {
		PH_COUNT,
		PH_VALUE,
		PH_ESC,
		PH_DX,
		PH_DY,
		PH_ABS,
		PH_PAD
	} phase_t;

	typedef enum logic [1:0] {
		CMD_RUN,
		CMD_EOL,
		CMD_EOB,
		CMD_DELTA
	} cmd_kind_t;

	// delta: cnt carries dx, idx_even carries dy
	typedef struct packed {
		cmd_kind_t          kind;
		logic [BYTE_W-1:0]  cnt;
		logic [IDX_W-1:0]   idx_even;
		logic [IDX_W-1:0]   idx_odd;
	} cmd_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_MUL,
		BK_CMP,
		BK_DIV
	} back_state_t;

endpackage

`default_nettype wire

>>> rtl/core/bmprle_front.sv
// Stream parser: turns compressed bytes into run, line, delta and end commands.
// Depends on bmprle_pkg.
`default_nettype none

module bmprle_front (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        nibble_mode,
	input  wire logic                        stream_valid,
	output logic                             stream_stall,
	input  wire logic [bmprle_pkg::BYTE_W-1:0] stream_byte,
	input  wire logic                        push_ready,
	output logic                             push_valid,
	output bmprle_pkg::cmd_t                 push_cmd
);

	bmprle_pkg::phase_t phase_q, phase_d;
	logic [bmprle_pkg::BYTE_W-1:0] held_q, held_d;
	logic [bmprle_pkg::BYTE_W-1:0] left_q, left_d;
	logic [bmprle_pkg::BYTE_W-1:0] dx_q, dx_d;
	logic pad_q, pad_d;

	logic acc;
	logic [bmprle_pkg::IDX_W-1:0] hi_idx, lo_idx;
	logic [bmprle_pkg::BYTE_W:0] abs_bytes;
	logic [bmprle_pkg::BYTE_W-1:0] take;

	assign acc          = stream_valid && push_ready;
	assign stream_stall = !push_ready;
	assign hi_idx       = (stream_byte >> 4) & bmprle_pkg::NIBBLE_MASK;
	assign lo_idx       = stream_byte & bmprle_pkg::NIBBLE_MASK;
	assign abs_bytes    = nibble_mode ? ((9'(stream_byte) + 9'd1) >> 1) : 9'(stream_byte);

	always_comb begin
		if (nibble_mode && left_q >= 8'd2) begin
			take = 8'd2;
		end else if (left_q >= 8'd1) begin
			take = 8'd1;
		end else begin
			take = 8'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= bmprle_pkg::PH_COUNT;
			held_q  <= '0;
			left_q  <= '0;
			dx_q    <= '0;
			pad_q   <= 1'b0;
		end else if (acc) begin
			phase_q <= phase_d;
			held_q  <= held_d;
			left_q  <= left_d;
			dx_q    <= dx_d;
			pad_q   <= pad_d;
		end
	end

	always_comb begin
		phase_d           = phase_q;
		held_d            = held_q;
		left_d            = left_q;
		dx_d              = dx_q;
		pad_d             = pad_q;
		push_valid        = 1'b0;
		push_cmd.kind     = bmprle_pkg::CMD_RUN;
		push_cmd.cnt      = '0;
		push_cmd.idx_even = nibble_mode ? hi_idx : stream_byte;
		push_cmd.idx_odd  = nibble_mode ? lo_idx : stream_byte;
		case (phase_q)
			bmprle_pkg::PH_COUNT: begin
				if (stream_byte != '0) begin
					held_d  = stream_byte;
					phase_d = bmprle_pkg::PH_VALUE;
				end else begin
					phase_d = bmprle_pkg::PH_ESC;
				end
			end
			bmprle_pkg::PH_VALUE: begin
				push_valid   = acc;
				push_cmd.cnt = held_q;
				phase_d      = bmprle_pkg::PH_COUNT;
			end
			bmprle_pkg::PH_ESC: begin
				if (stream_byte == bmprle_pkg::ESC_EOL) begin
					push_valid    = acc;
					push_cmd.kind = bmprle_pkg::CMD_EOL;
					phase_d       = bmprle_pkg::PH_COUNT;
				end else if (stream_byte == bmprle_pkg::ESC_EOB) begin
					push_valid    = acc;
					push_cmd.kind = bmprle_pkg::CMD_EOB;
					held_d        = '0;
					left_d        = '0;
					dx_d          = '0;
					pad_d         = 1'b0;
					phase_d       = bmprle_pkg::PH_COUNT;
				end else if (stream_byte == bmprle_pkg::ESC_DELTA) begin
					phase_d = bmprle_pkg::PH_DX;
				end else begin
					left_d  = stream_byte;
					pad_d   = abs_bytes[0];
					phase_d = bmprle_pkg::PH_ABS;
				end
			end
			bmprle_pkg::PH_DX: begin
				dx_d    = stream_byte;
				phase_d = bmprle_pkg::PH_DY;
			end
			bmprle_pkg::PH_DY: begin
				push_valid        = acc;
				push_cmd.kind     = bmprle_pkg::CMD_DELTA;
				push_cmd.cnt      = dx_q;
				push_cmd.idx_even = stream_byte;
				phase_d           = bmprle_pkg::PH_COUNT;
			end
			bmprle_pkg::PH_ABS: begin
				push_valid   = acc;
				push_cmd.cnt = take;
				left_d       = left_q - take;
				if (left_d == '0) begin
					phase_d = pad_q ? bmprle_pkg::PH_PAD : bmprle_pkg::PH_COUNT;
				end
			end
			bmprle_pkg::PH_PAD: begin
				pad_d   = 1'b0;
				phase_d = bmprle_pkg::PH_COUNT;
			end
			default: begin
				phase_d = bmprle_pkg::PH_COUNT;
			end
		endcase
	end

endmodule

`default_nettype wire

>>> rtl/core/bmprle_fifo.sv
// Short command queue between parser and run executor.
// Depends on bmprle_pkg.
`default_nettype none

module bmprle_fifo (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       push_valid,
	input  wire bmprle_pkg::cmd_t push_cmd,
	output logic            push_ready,
	output logic            pop_valid,
	output bmprle_pkg::cmd_t pop_cmd,
	input  wire logic       pop
);

	localparam int DEPTH = bmprle_pkg::QUEUE_DEPTH;
	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	bmprle_pkg::cmd_t store_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic do_push, do_pop;

	assign push_ready = (count_q != CNT_W'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_cmd    = store_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop && pop_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			store_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(wr_ptr_q + 1'b1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(rd_ptr_q + 1'b1);
			end
			if (do_push && !do_pop) begin
				count_q <= CNT_W'(count_q + 1'b1);
			end else if (do_pop && !do_push) begin
				count_q <= CNT_W'(count_q - 1'b1);
			end
		end
	end

endmodule

`default_nettype wire

>>> rtl/core/bmprle_back.sv
// Run executor: tracks column and line, clips runs, resolves delta moves,
// and holds the result register. Depends on bmprle_pkg.
`default_nettype none

module bmprle_back #(
	parameter int MAX_WIDTH  = bmprle_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = bmprle_pkg::DEF_MAX_HEIGHT
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic [$clog2(MAX_WIDTH+1)-1:0]     img_w,
	input  wire logic [$clog2(MAX_HEIGHT+1)-1:0]    img_h,
	input  wire logic                               bottom_up,
	input  wire logic                               cmd_valid,
	input  wire bmprle_pkg::cmd_t                   cmd,
	output logic                                    cmd_pop,
	output logic                                    run_valid,
	input  wire logic                               run_stall,
	output logic [bmprle_pkg::X_W-1:0]              start_x,
	output logic [bmprle_pkg::ROW_W-1:0]            start_row,
	output logic [bmprle_pkg::COUNT_W-1:0]          pixel_count,
	output logic [bmprle_pkg::IDX_W-1:0]            index_even,
	output logic [bmprle_pkg::IDX_W-1:0]            index_odd,
	output logic                                    end_of_image
);

	localparam int W_W    = $clog2(MAX_WIDTH + 1);
	localparam int H_W    = $clog2(MAX_HEIGHT + 1);
	localparam int B_W    = bmprle_pkg::BYTE_W;
	localparam int N_W    = (W_W > B_W) ? W_W : B_W;
	localparam int P_W    = W_W + H_W;
	localparam int F_W    = W_W + B_W;
	localparam int CMP_W  = ((P_W > F_W) ? P_W : F_W) + 1;
	localparam int S_W    = N_W + 1;
	localparam int D_W    = W_W + bmprle_pkg::QUO_W;
	localparam int STEP_W = $clog2(bmprle_pkg::DIV_STEPS);
	localparam int QW     = bmprle_pkg::QUO_W;

	bmprle_pkg::back_state_t bst_q, bst_d;
	logic [W_W-1:0] col_q, col_d;
	logic [H_W-1:0] line_q, line_d;
	logic [STEP_W-1:0] step_q, step_d;
	logic run_valid_q, run_valid_d;

	logic [B_W-1:0] dx_q, dy_q;
	logic [W_W-1:0] xn_q;
	logic [H_W-1:0] ln_q, base_q;
	logic in_img_q;
	logic [P_W-1:0] prod_rem_q;
	logic [F_W-1:0] prod_f_q;
	logic [S_W-1:0] div_rem_q;
	logic [QW-1:0] quo_q;

	logic at_end;
	logic [W_W-1:0] xn, room, run_n;
	logic [H_W-1:0] ln, h_left;
	logic [N_W-1:0] cnt_ext, room_ext;
	logic out_free;
	logic [P_W-1:0] prod_rem_v;
	logic [F_W-1:0] prod_f_v;
	logic [CMP_W-1:0] rem_v, f_v, dn;
	logic clip;
	logic [D_W-1:0] dvs, dr_ext;
	logic dfit;
	logic [S_W-1:0] dr_next;
	logic [QW-1:0] quo_next;
	logic delta_start, delta_div;

	logic e_load, e_eoi;
	logic [W_W-1:0] e_x;
	logic [H_W-1:0] e_line, e_row;
	logic [CMP_W-1:0] e_n;
	logic [bmprle_pkg::IDX_W-1:0] e_ev, e_od;

	assign at_end   = (col_q == img_w);
	assign xn       = at_end ? '0 : col_q;
	assign ln       = at_end ? H_W'(line_q + 1'b1) : line_q;
	assign room     = (line_q < img_h && col_q < img_w) ? W_W'(img_w - col_q) : '0;
	assign cnt_ext  = N_W'(cmd.cnt);
	assign room_ext = N_W'(room);
	assign run_n    = W_W'((cnt_ext < room_ext) ? cnt_ext : room_ext);
	assign out_free = !run_valid_q || !run_stall;
	assign cmd_pop  = cmd_valid && (bst_q == bmprle_pkg::BK_IDLE) && out_free;

	assign h_left     = H_W'(img_h - ln_q);
	assign prod_rem_v = h_left * img_w;
	assign prod_f_v   = dy_q * img_w;
	assign rem_v      = CMP_W'(prod_rem_q) - CMP_W'(xn_q);
	assign f_v        = CMP_W'(prod_f_q) + CMP_W'(dx_q);
	assign clip       = !in_img_q || (f_v >= rem_v);
	assign dn         = clip ? rem_v : f_v;

	assign dvs      = D_W'(img_w) << step_q;
	assign dr_ext   = D_W'(div_rem_q);
	assign dfit     = (dr_ext >= dvs);
	assign dr_next  = dfit ? S_W'(dr_ext - dvs) : div_rem_q;
	assign quo_next = dfit ? (quo_q | (QW'(1) << step_q)) : quo_q;

	assign e_row = bottom_up ? H_W'(img_h - 1'b1 - e_line) : e_line;

	always_comb begin
		bst_d       = bst_q;
		col_d       = col_q;
		line_d      = line_q;
		step_d      = step_q;
		delta_start = 1'b0;
		delta_div   = 1'b0;
		e_load      = 1'b0;
		e_eoi       = 1'b0;
		e_x         = col_q;
		e_line      = line_q;
		e_n         = '0;
		e_ev        = '0;
		e_od        = '0;
		case (bst_q)
			bmprle_pkg::BK_IDLE: begin
				if (cmd_pop) begin
					case (cmd.kind)
						bmprle_pkg::CMD_RUN: begin
							if (run_n != '0) begin
								e_load = 1'b1;
								e_n    = CMP_W'(run_n);
								e_ev   = cmd.idx_even;
								e_od   = cmd.idx_odd;
								col_d  = W_W'(col_q + run_n);
							end
						end
						bmprle_pkg::CMD_EOL: begin
							if (room != '0) begin
								e_load = 1'b1;
								e_n    = CMP_W'(room);
							end
							if (line_q < H_W'(MAX_HEIGHT)) begin
								line_d = H_W'(line_q + 1'b1);
							end
							col_d = '0;
						end
						bmprle_pkg::CMD_EOB: begin
							e_load = 1'b1;
							e_eoi  = 1'b1;
							col_d  = '0;
							line_d = '0;
						end
						bmprle_pkg::CMD_DELTA: begin
							delta_start = 1'b1;
							bst_d       = bmprle_pkg::BK_MUL;
						end
						default: begin
						end
					endcase
				end
			end
			bmprle_pkg::BK_MUL: begin
				bst_d = bmprle_pkg::BK_CMP;
			end
			bmprle_pkg::BK_CMP: begin
				if (out_free) begin
					if (in_img_q && dn != '0) begin
						e_load = 1'b1;
						e_x    = xn_q;
						e_line = ln_q;
						e_n    = dn;
					end
					if (clip) begin
						line_d = img_h;
						col_d  = '0;
						bst_d  = bmprle_pkg::BK_IDLE;
					end else begin
						step_d = STEP_W'(bmprle_pkg::DIV_STEPS - 1);
						bst_d  = bmprle_pkg::BK_DIV;
					end
				end
			end
			bmprle_pkg::BK_DIV: begin
				delta_div = 1'b1;
				if (step_q == '0) begin
					col_d  = W_W'(dr_next);
					line_d = H_W'(base_q + quo_next);
					bst_d  = bmprle_pkg::BK_IDLE;
				end else begin
					step_d = STEP_W'(step_q - 1'b1);
				end
			end
			default: begin
				bst_d = bmprle_pkg::BK_IDLE;
			end
		endcase
		run_valid_d = e_load ? 1'b1 : (run_stall ? run_valid_q : 1'b0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bst_q       <= bmprle_pkg::BK_IDLE;
			col_q       <= '0;
			line_q      <= '0;
			step_q      <= '0;
			run_valid_q <= 1'b0;
		end else begin
			bst_q       <= bst_d;
			col_q       <= col_d;
			line_q      <= line_d;
			step_q      <= step_d;
			run_valid_q <= run_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		if (delta_start) begin
			dx_q     <= cmd.cnt;
			dy_q     <= cmd.idx_even;
			xn_q     <= xn;
			ln_q     <= ln;
			in_img_q <= (ln < img_h);
		end
		if (bst_q == bmprle_pkg::BK_MUL) begin
			prod_rem_q <= prod_rem_v;
			prod_f_q   <= prod_f_v;
		end
		if (bst_q == bmprle_pkg::BK_CMP) begin
			div_rem_q <= S_W'(xn_q) + S_W'(dx_q);
			quo_q     <= '0;
			base_q    <= H_W'(ln_q + dy_q);
		end
		if (delta_div) begin
			div_rem_q <= dr_next;
			quo_q     <= quo_next;
		end
		if (e_load) begin
			start_x      <= e_eoi ? '0 : bmprle_pkg::X_W'(e_x);
			start_row    <= e_eoi ? '0 : bmprle_pkg::ROW_W'(e_row);
			pixel_count  <= bmprle_pkg::COUNT_W'(e_n);
			index_even   <= e_ev;
			index_odd    <= e_od;
			end_of_image <= e_eoi;
		end
	end

	assign run_valid = run_valid_q;

endmodule

`default_nettype wire

>>> rtl/core/bitmap_rle_run_decoder_core.sv
// Top level of the bitmap RLE run decoder: config registers, parser, queue, executor.
// Depends on bmprle_pkg, bmprle_front, bmprle_fifo and bmprle_back.
//
// Usage:
//   cfg channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes nibble_mode,
//   image_width, image_height and bottom_up; cfg_ready is always high. Write
//   only while the decoder is idle.
//   stream channel (stream_valid/stream_stall) takes one compressed byte per
//   cycle while stream_stall is low; run channel (run_valid/run_stall) gives
//   at most one run per byte. Throughput: one byte per cycle for runs, end of
//   line and end of bitmap while run_stall is low. A delta escape holds the
//   executor through command pickup, one multiply stage, one compare stage and,
//   unless the move is clipped, nine divider steps for the new column.
//   A result passes the command queue, then the output register.
//   A 4-entry command queue parts parser and executor; stream_stall rises
//   when it is full. A stalled result stays in the output register.
//   Reset: RLE8, width 1, height 1, bottom-up, position at column 0 line 0.
`default_nettype none

module bitmap_rle_run_decoder_core #(
	parameter int MAX_WIDTH  = bmprle_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = bmprle_pkg::DEF_MAX_HEIGHT
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_valid,
	output logic                                   cfg_ready,
	input  wire logic [bmprle_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [bmprle_pkg::CFG_DATA_W-1:0] cfg_data,
	input  wire logic                              stream_valid,
	output logic                                   stream_stall,
	input  wire logic [bmprle_pkg::BYTE_W-1:0]     stream_byte,
	output logic                                   run_valid,
	input  wire logic                              run_stall,
	output logic [bmprle_pkg::X_W-1:0]             start_x,
	output logic [bmprle_pkg::ROW_W-1:0]           start_row,
	output logic [bmprle_pkg::COUNT_W-1:0]         pixel_count,
	output logic [bmprle_pkg::IDX_W-1:0]           index_even,
	output logic [bmprle_pkg::IDX_W-1:0]           index_odd,
	output logic                                   end_of_image
);

	localparam int W_W = $clog2(MAX_WIDTH + 1);
	localparam int H_W = $clog2(MAX_HEIGHT + 1);

	logic nibble_mode_q, bottom_up_q;
	logic [W_W-1:0] image_width_q, w_clamp;
	logic [H_W-1:0] image_height_q, h_clamp;
	logic cfg_wr;

	logic push_valid, push_ready, pop_valid, pop;
	bmprle_pkg::cmd_t push_cmd, pop_cmd;

	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && cfg_ready;

	assign w_clamp = (cfg_data == '0) ? W_W'(1) :
		(32'(cfg_data) > MAX_WIDTH) ? W_W'(MAX_WIDTH) : W_W'(cfg_data);
	assign h_clamp = (cfg_data == '0) ? H_W'(1) :
		(32'(cfg_data) > MAX_HEIGHT) ? H_W'(MAX_HEIGHT) : H_W'(cfg_data);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nibble_mode_q  <= 1'b0;
			image_width_q  <= W_W'(1);
			image_height_q <= H_W'(1);
			bottom_up_q    <= 1'b1;
		end else if (cfg_wr) begin
			case (cfg_index)
				bmprle_pkg::REG_NIBBLE_MODE:  nibble_mode_q  <= cfg_data[0];
				bmprle_pkg::REG_IMAGE_WIDTH:  image_width_q  <= w_clamp;
				bmprle_pkg::REG_IMAGE_HEIGHT: image_height_q <= h_clamp;
				bmprle_pkg::REG_BOTTOM_UP:    bottom_up_q    <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	bmprle_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.nibble_mode  (nibble_mode_q),
		.stream_valid (stream_valid),
		.stream_stall (stream_stall),
		.stream_byte  (stream_byte),
		.push_ready   (push_ready),
		.push_valid   (push_valid),
		.push_cmd     (push_cmd)
	);

	bmprle_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_cmd   (push_cmd),
		.push_ready (push_ready),
		.pop_valid  (pop_valid),
		.pop_cmd    (pop_cmd),
		.pop        (pop)
	);

	bmprle_back #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.img_w        (image_width_q),
		.img_h        (image_height_q),
		.bottom_up    (bottom_up_q),
		.cmd_valid    (pop_valid),
		.cmd          (pop_cmd),
		.cmd_pop      (pop),
		.run_valid    (run_valid),
		.run_stall    (run_stall),
		.start_x      (start_x),
		.start_row    (start_row),
		.pixel_count  (pixel_count),
		.index_even   (index_even),
		.index_odd    (index_odd),
		.end_of_image (end_of_image)
	);

endmodule

`default_nettype wire

>>> rtl/core/bmprle_checker.sv
// Port-level assertions for the bitmap RLE run decoder, bound to the top level.
// Depends on bitmap_rle_run_decoder_core_defines.svh and bmprle_pkg.
`default_nettype none
`include "bitmap_rle_run_decoder_core_defines.svh"

module bmprle_checker (
	input wire logic                              clk,
	input wire logic                              arst_n,
	input wire logic                              run_valid,
	input wire logic                              run_stall,
	input wire logic [bmprle_pkg::X_W-1:0]        start_x,
	input wire logic [bmprle_pkg::ROW_W-1:0]      start_row,
	input wire logic [bmprle_pkg::COUNT_W-1:0]    pixel_count,
	input wire logic [bmprle_pkg::IDX_W-1:0]      index_even,
	input wire logic [bmprle_pkg::IDX_W-1:0]      index_odd,
	input wire logic                              end_of_image
);

	`BRD_ASSERT_NEXT(a_valid_held, run_valid && run_stall, run_valid, "run dropped while stalled")

	`BRD_ASSERT_NEXT(a_run_held, run_valid && run_stall, $stable(pixel_count) && $stable(start_x) && $stable(start_row), "run changed while stalled")

	`BRD_ASSERT(a_run_nonempty, run_valid && !end_of_image |-> pixel_count != '0, "empty run reported")

	`BRD_ASSERT(a_eoi_clear, run_valid && end_of_image |-> start_x == '0 && start_row == '0 && pixel_count == '0 && index_even == '0 && index_odd == '0, "end marker with run fields")

endmodule

bind bitmap_rle_run_decoder_core bmprle_checker u_checker (.*);

`default_nettype wire

>>> sim/tb.sv
`timescale 1ns / 1ps
// Testbench for bitmap_rle_run_decoder_core: feeds RLE8/RLE4 byte streams under random gaps
// and stalls and checks every run against an in-bench decoder. Needs bmprle_pkg and the core.

module tb;
	import bmprle_pkg::*;

	localparam int MAX_WIDTH   = DEF_MAX_WIDTH;
	localparam int MAX_HEIGHT  = DEF_MAX_HEIGHT;
	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int DRAIN       = 64;
	localparam logic [BYTE_W-1:0] ESC_LEAD = 8'h00;

	typedef struct packed {
		logic [X_W-1:0]     x;
		logic [ROW_W-1:0]   row;
		logic [COUNT_W-1:0] count;
		logic [IDX_W-1:0]   ev;
		logic [IDX_W-1:0]   od;
		logic               eoi;
	} run_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic stream_valid;
	logic stream_stall;
	logic [BYTE_W-1:0] stream_byte;
	logic run_valid;
	logic run_stall = 1'b0;
	logic [X_W-1:0] start_x;
	logic [ROW_W-1:0] start_row;
	logic [COUNT_W-1:0] pixel_count;
	logic [IDX_W-1:0] index_even;
	logic [IDX_W-1:0] index_odd;
	logic end_of_image;

	// decoder state and register copies
	phase_t ps = PH_COUNT;
	int unsigned held = 0;
	int unsigned abs_left = 0;
	bit pad_due = 1'b0;
	int unsigned dx_held = 0;
	int unsigned col = 0;
	int unsigned ln = 0;
	bit cfg_nib = 1'b0;
	int unsigned cfg_width = 1;
	int unsigned cfg_height = 1;
	bit cfg_bottom = 1'b1;

	run_t runs_due[$];
	run_t want;
	bit steady = 1'b0;
	int unsigned stall_left = 0;
	int unsigned hold;
	int unsigned cycles = 0;
	int unsigned errors = 0;
	int unsigned bytes_sent = 0;
	int unsigned runs_checked = 0;
	int unsigned eoi_seen = 0;
	int unsigned settings = 0;

	bitmap_rle_run_decoder_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.stream_valid(stream_valid),
		.stream_stall(stream_stall),
		.stream_byte(stream_byte),
		.run_valid(run_valid),
		.run_stall(run_stall),
		.start_x(start_x),
		.start_row(start_row),
		.pixel_count(pixel_count),
		.index_even(index_even),
		.index_odd(index_odd),
		.end_of_image(end_of_image)
	);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d runs still expected", cycles, runs_due.size());
			$display("DONE: errors detected");
			$finish;
		end
	end

	function automatic int unsigned draw_wait();
		if (steady || $urandom_range(0, 2) == 0)
			return 0;
		return $urandom_range(0, 17);
	endfunction

	function automatic int unsigned clamp_dim(input int unsigned v, input int unsigned lim);
		if (v < 1)
			return 1;
		if (v > lim)
			return lim;
		return v;
	endfunction

	function automatic int unsigned row_room();
		int unsigned w;
		w = clamp_dim(cfg_width, MAX_WIDTH);
		if (ln >= clamp_dim(cfg_height, MAX_HEIGHT) || col >= w)
			return 0;
		return w - col;
	endfunction

	function automatic run_t make_run(input longint unsigned x, input longint unsigned at_line,
			input longint unsigned cnt, input logic [IDX_W-1:0] ev, input logic [IDX_W-1:0] od);
		run_t r;
		longint unsigned h;
		longint unsigned row;
		h = clamp_dim(cfg_height, MAX_HEIGHT);
		row = cfg_bottom ? h - 1 - at_line : at_line;
		r.x = X_W'(x);
		r.row = ROW_W'(row);
		r.count = COUNT_W'(cnt);
		r.ev = ev;
		r.od = od;
		r.eoi = 1'b0;
		return r;
	endfunction

	// advance the decoder by one stream byte; returns 1 when a run is reported
	function automatic bit decode_byte(input logic [BYTE_W-1:0] b, output run_t r);
		int unsigned w;
		int unsigned h;
		int unsigned room;
		int unsigned n;
		int unsigned take;
		int unsigned nbytes;
		longint unsigned total;
		longint unsigned p;
		longint unsigned f;
		longint unsigned np;
		longint unsigned cnt;
		logic [IDX_W-1:0] hi;
		logic [IDX_W-1:0] lo;
		bit got;
		w = clamp_dim(cfg_width, MAX_WIDTH);
		h = clamp_dim(cfg_height, MAX_HEIGHT);
		hi = (b >> 4) & NIBBLE_MASK;
		lo = b & NIBBLE_MASK;
		got = 1'b0;
		r = '0;
		case (ps)
			PH_COUNT: begin
				if (b != ESC_LEAD) begin
					held = b;
					ps = PH_VALUE;
				end else begin
					ps = PH_ESC;
				end
			end
			PH_VALUE: begin
				room = row_room();
				n = held < room ? held : room;
				if (n > 0) begin
					r = cfg_nib ? make_run(col, ln, n, hi, lo) : make_run(col, ln, n, b, b);
					got = 1'b1;
					col += n;
				end
				ps = PH_COUNT;
			end
			PH_ESC: begin
				if (b == ESC_EOL) begin
					room = row_room();
					if (room > 0) begin
						r = make_run(col, ln, room, '0, '0);
						got = 1'b1;
					end
					if (ln < MAX_HEIGHT)
						ln++;
					col = 0;
					ps = PH_COUNT;
				end else if (b == ESC_EOB) begin
					r.eoi = 1'b1;
					got = 1'b1;
					col = 0;
					ln = 0;
					held = 0;
					abs_left = 0;
					pad_due = 1'b0;
					dx_held = 0;
					ps = PH_COUNT;
				end else if (b == ESC_DELTA) begin
					ps = PH_DX;
				end else begin
					nbytes = cfg_nib ? (int'(b) + 1) >> 1 : int'(b);
					abs_left = b;
					pad_due = nbytes[0];
					ps = PH_ABS;
				end
			end
			PH_DX: begin
				dx_held = b;
				ps = PH_DY;
			end
			PH_DY: begin
				total = longint'(w) * h;
				p = longint'(ln) * w + col;
				f = longint'(dx_held) + longint'(b) * w;
				np = p + f;
				if (p < total) begin
					cnt = (np > total) ? total - p : f;
					if (cnt > 0) begin
						r = make_run(p % w, p / w, cnt, '0, '0);
						got = 1'b1;
					end
				end
				if (np > total)
					np = total;
				ln = int'(np / w);
				col = int'(np % w);
				ps = PH_COUNT;
			end
			PH_ABS: begin
				take = (cfg_nib && abs_left >= 2) ? 2 : 1;
				if (take > abs_left)
					take = abs_left;
				abs_left -= take;
				room = row_room();
				n = take < room ? take : room;
				if (n > 0) begin
					r = cfg_nib ? make_run(col, ln, n, hi, lo) : make_run(col, ln, n, b, b);
					got = 1'b1;
					col += n;
				end
				if (abs_left == 0)
					ps = pad_due ? PH_PAD : PH_COUNT;
			end
			PH_PAD: begin
				pad_due = 1'b0;
				ps = PH_COUNT;
			end
			default: ps = PH_COUNT;
		endcase
		return got;
	endfunction

	// valid stays high across back-to-back items
	task automatic push_byte(input logic [BYTE_W-1:0] b);
		int unsigned gap;
		run_t r;
		gap = draw_wait();
		if (gap != 0) begin
			stream_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		stream_valid <= 1'b1;
		stream_byte <= b;
		do @(posedge clk); while (stream_stall);
		bytes_sent++;
		if (decode_byte(b, r))
			runs_due.push_back(r);
	endtask

	task automatic settle();
		stream_valid <= 1'b0;
		while (runs_due.size() != 0) @(posedge clk);
		repeat (DRAIN) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= CFG_DATA_W'(val);
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			REG_NIBBLE_MODE:  cfg_nib = val[0];
			REG_IMAGE_WIDTH:  cfg_width = val & 32'h1FFF;
			REG_IMAGE_HEIGHT: cfg_height = val & 32'h1FFF;
			REG_BOTTOM_UP:    cfg_bottom = val[0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic set_image(input int unsigned nib, input int unsigned w, input int unsigned h,
			input int unsigned bu);
		settle();
		write_reg(REG_NIBBLE_MODE, nib);
		write_reg(REG_IMAGE_WIDTH, w);
		write_reg(REG_IMAGE_HEIGHT, h);
		write_reg(REG_BOTTOM_UP, bu);
		settings++;
	endtask

	// bring the parser back to the count byte, then end the bitmap
	task automatic close_image();
		while (ps != PH_COUNT) push_byte(ESC_LEAD);
		push_byte(ESC_LEAD);
		push_byte(ESC_EOB);
	endtask

	function automatic int unsigned pick_dim();
		case ($urandom_range(0, 3))
			0: return $urandom_range(1, 8);
			3: return $urandom_range(1, 8191);
			default: return $urandom_range(1, 64);
		endcase
	endfunction

	task automatic send_sequence();
		int unsigned pick;
		int unsigned n;
		int unsigned nbytes;
		pick = $urandom_range(0, 99);
		if (pick < 40) begin
			n = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 255) : $urandom_range(1, 20);
			push_byte(BYTE_W'(n));
			push_byte(BYTE_W'($urandom_range(0, 255)));
		end else if (pick < 55) begin
			push_byte(ESC_LEAD);
			push_byte(ESC_EOL);
		end else if (pick < 59) begin
			push_byte(ESC_LEAD);
			push_byte(ESC_EOB);
		end else if (pick < 72) begin
			push_byte(ESC_LEAD);
			push_byte(ESC_DELTA);
			push_byte(BYTE_W'($urandom_range(0, 255)));
			push_byte(BYTE_W'(($urandom_range(0, 4) == 0) ? $urandom_range(0, 255)
				: $urandom_range(0, 3)));
		end else if (pick < 90) begin
			n = ($urandom_range(0, 19) == 0) ? $urandom_range(3, 255) : $urandom_range(3, 12);
			nbytes = cfg_nib ? (n + 1) >> 1 : n;
			push_byte(ESC_LEAD);
			push_byte(BYTE_W'(n));
			repeat (nbytes) push_byte(BYTE_W'($urandom_range(0, 255)));
			if (nbytes[0])
				push_byte(BYTE_W'($urandom_range(0, 255)));
		end else begin
			repeat ($urandom_range(1, 4)) push_byte(BYTE_W'($urandom_range(0, 255)));
		end
	endtask

	task automatic test_reset_defaults();
		push_byte(8'd4);
		push_byte(8'h7E);
		push_byte(ESC_LEAD);
		push_byte(ESC_EOL);
		close_image();
	endtask

	// full, clipped and empty runs, padded absolute, delta inside and past the image
	task automatic test_rle8_directed();
		logic [BYTE_W-1:0] seq [$] = '{8'd3, 8'h00, 8'd255, 8'hFF, 8'd2, 8'h55,
			ESC_LEAD, 8'd3, 8'h11, 8'h22, 8'h33, 8'h00, ESC_LEAD, ESC_DELTA, 8'd5, 8'd1,
			ESC_LEAD, ESC_EOL, ESC_LEAD, ESC_DELTA, 8'hFF, 8'hFF};
		set_image(0, 16, 8, 0);
		foreach (seq[i]) push_byte(seq[i]);
		close_image();
	endtask

	task automatic test_rle4_directed();
		logic [BYTE_W-1:0] seq [$] = '{8'd5, 8'hAB, ESC_LEAD, 8'd5, 8'h12, 8'h34, 8'h56,
			8'h00, ESC_LEAD, 8'd4, 8'h9C, 8'hDE};
		set_image(1, 10, 4, 1);
		foreach (seq[i]) push_byte(seq[i]);
		close_image();
	endtask

	// walk past the last line with deltas, then end of line must saturate
	task automatic test_image_end_saturation();
		set_image(0, 4096, 8191, 1);
		while (ln < MAX_HEIGHT) begin
			push_byte(ESC_LEAD);
			push_byte(ESC_DELTA);
			push_byte(8'hFF);
			push_byte(8'hFF);
		end
		repeat (2) begin
			push_byte(ESC_LEAD);
			push_byte(ESC_EOL);
		end
		push_byte(8'd1);
		push_byte(8'h10);
		close_image();
	endtask

	task automatic test_random_streams();
		int unsigned target;
		bit paused;
		paused = 1'b0;
		for (int ph = 0; ph < 8; ph++) begin
			case (ph)
				0: set_image(0, 1, 1, 1);
				1: set_image(1, 4096, 4096, 0);
				2: set_image(0, 0, 0, 0);
				default: set_image($urandom_range(0, 1), pick_dim(), pick_dim(),
					$urandom_range(0, 1));
			endcase
			target = bytes_sent + 135;
			while (bytes_sent < target) begin
				steady = ($urandom_range(0, 4) == 0);
				send_sequence();
				if (ph == 3 && !paused && bytes_sent + 75 > target) begin
					settle();
					paused = 1'b1;
				end
			end
			steady = 1'b0;
			close_image();
		end
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (run_valid && !run_stall) begin
				if (runs_due.size() == 0) begin
					$error("unexpected run: x %0d row %0d count %0d eoi %0d",
						start_x, start_row, pixel_count, end_of_image);
					errors++;
				end else begin
					want = runs_due.pop_front();
					if (start_x !== want.x) begin
						$error("start_x: expected %0d, actual %0d", want.x, start_x);
						errors++;
					end
					if (start_row !== want.row) begin
						$error("start_row: expected %0d, actual %0d", want.row, start_row);
						errors++;
					end
					if (pixel_count !== want.count) begin
						$error("pixel_count: expected %0d, actual %0d", want.count, pixel_count);
						errors++;
					end
					if (index_even !== want.ev) begin
						$error("index_even: expected %0d, actual %0d", want.ev, index_even);
						errors++;
					end
					if (index_odd !== want.od) begin
						$error("index_odd: expected %0d, actual %0d", want.od, index_odd);
						errors++;
					end
					if (end_of_image !== want.eoi) begin
						$error("end_of_image: expected %0d, actual %0d", want.eoi, end_of_image);
						errors++;
					end
					runs_checked++;
					if (want.eoi)
						eoi_seen++;
				end
				hold = draw_wait();
				stall_left <= hold;
				run_stall <= (hold != 0);
			end else if (stall_left != 0) begin
				stall_left <= stall_left - 1;
				run_stall <= (stall_left > 1);
			end
		end
	end

	initial begin
		arst_n <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		stream_valid <= 1'b0;
		stream_byte <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_rle8_directed();
		test_rle4_directed();
		test_image_end_saturation();
		test_random_streams();
		settle();
		$display("Covered %0d image settings in RLE8 and RLE4 with %0d stream bytes;",
			settings, bytes_sent);
		$display("%0d runs checked, %0d of them end-of-bitmap markers.", runs_checked, eoi_seen);
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

>>> files.f
+incdir+rtl/core
rtl/core/bmprle_pkg.sv
rtl/core/bmprle_front.sv
rtl/core/bmprle_fifo.sv
rtl/core/bmprle_back.sv
rtl/core/bitmap_rle_run_decoder_core.sv
rtl/core/bmprle_checker.sv
sim/tb.sv
